// ===== sv/bpa_pkg.sv =====
// Shared types, constants and codes of the buddy page allocator.
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int NUM_LISTS  = 16;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = PAGE_W + 1;
  localparam int ORD_W      = 4;
  localparam int K_W        = ORD_W + 1;
  localparam int BASE_W     = 36;
  localparam int IDX_W      = 12;
  localparam int FREE_W     = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BAD    = 2'd2,
    ST_DOUBLE = 2'd3
  } stat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_RSVD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_I_RES, S_I_CARVE, S_I_FILL, S_I_NEXT,
    S_A_CHK, S_A_SRCH, S_A_SPLIT,
    S_F_CHK, S_F_META, S_F_LOOP, S_F_BUD, S_F_MERGE, S_F_ORD, S_F_FIN, S_F_DONE,
    S_PT1, S_PT2, S_PH1, S_PH2, S_U1, S_U2, S_U3, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ORD_W-1:0] request_order;
    logic [IDX_W-1:0] page_index;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  block_index;
    logic [FREE_W-1:0] free_total;
  } bpa_rsp_t;

  typedef struct packed {
    logic             alloc;
    logic [ORD_W-1:0] order;
    logic [ORD_W-1:0] limit;
  } meta_t;

  typedef struct packed {
    logic              rd;
    logic              wr_alloc;
    logic              wr_order;
    logic              wr_limit;
    logic [PAGE_W-1:0] addr;
    meta_t             wdata;
  } meta_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } link_t;

  typedef struct packed {
    logic              rd;
    logic              wr_next;
    logic              wr_prev;
    logic [PAGE_W-1:0] addr;
    link_t             wdata;
  } link_req_t;

endpackage

// ===== sv/bpa_meta_mem.sv =====
// Per-page metadata memory: allocated mark, order and merge limit, field write enables.
module bpa_meta_mem import bpa_pkg::*; (
  input  logic      clk_i,
  input  meta_req_t req_i,
  output meta_t     rdata_o
);

  logic             alloc_mem [NUM_PAGES];
  logic [ORD_W-1:0] order_mem [NUM_PAGES];
  logic [ORD_W-1:0] limit_mem [NUM_PAGES];
  meta_t            rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_alloc) alloc_mem[req_i.addr] <= req_i.wdata.alloc;
    if (req_i.wr_order) order_mem[req_i.addr] <= req_i.wdata.order;
    if (req_i.wr_limit) limit_mem[req_i.addr] <= req_i.wdata.limit;
    if (req_i.rd) begin
      rdata_q <= '{alloc: alloc_mem[req_i.addr], order: order_mem[req_i.addr],
                   limit: limit_mem[req_i.addr]};
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bpa_link_mem.sv =====
// Per-page free list link memory: next and prev links, field write enables.
module bpa_link_mem import bpa_pkg::*; (
  input  logic      clk_i,
  input  link_req_t req_i,
  output link_t     rdata_o
);

  logic [LINK_W-1:0] next_mem [NUM_PAGES];
  logic [LINK_W-1:0] prev_mem [NUM_PAGES];
  link_t             rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_next) next_mem[req_i.addr] <= req_i.wdata.next;
    if (req_i.wr_prev) prev_mem[req_i.addr] <= req_i.wdata.prev;
    if (req_i.rd) begin
      rdata_q <= '{next: next_mem[req_i.addr], prev: prev_mem[req_i.addr]};
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/buddy_page_allocator_unit.sv =====
// Top level of the buddy page allocator: request sequencer, list registers, config.
//
// Usage: raise start with a request on req_i while busy is low; the request
// (init, alloc or free) is taken at that edge and busy rises. When the work is
// done, done_o pulses for one cycle with rsp_o (status, block head, free page
// count) and busy falls in the next cycle. The receiver cannot stall: rsp_o is
// valid only in the done_o cycle.
// One request at a time. Alloc searches upward past empty orders, unlinks the
// block found and splits it down, pushing each upper half at a list tail; free
// checks the metadata, merges level by level with free buddies and pushes the
// result at a list head; init marks the reserved pages, then writes every
// region page while carving blocks. Each step goes through the single-port
// metadata and link memories, read-modify-write with a registered read.
// Config: cfg_valid_i/cfg_ready_o write register cfg_index_i (0 base frame,
// 1 page count, 2 reserved pages); ready is always high. Values are latched
// at the next init. Reset leaves the allocator empty: no clearing pass runs,
// since init writes every page of the region before any page is read.
module buddy_page_allocator_unit import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bpa_req_t             req_i,
  output logic                 done_o,
  output bpa_rsp_t             rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_data_i
);

  // config registers
  logic [BASE_W-1:0] cfg_base_q;
  logic [LINK_W-1:0] cfg_count_q, cfg_res_q;

  // control state
  state_e            state_q, state_d, ret_q, ret_d;
  logic [BASE_W-1:0] held_base_q, held_base_d;
  logic [LINK_W-1:0] held_n_q, held_n_d, held_r_q, held_r_d;
  logic [ORD_W-1:0]  largest_q, largest_d;
  logic [LINK_W-1:0] free_q, free_d;
  logic [LINK_W-1:0] cnt_q [NUM_LISTS];
  logic [LINK_W-1:0] cnt_d [NUM_LISTS];

  // working registers
  logic [LINK_W-1:0] head_q [NUM_LISTS];
  logic [LINK_W-1:0] head_d [NUM_LISTS];
  logic [LINK_W-1:0] tail_q [NUM_LISTS];
  logic [LINK_W-1:0] tail_d [NUM_LISTS];
  logic [ORD_W-1:0]  ord_q, ord_d, mo_q, mo_d, o_q, o_d, lim_q, lim_d, h_ord_q, h_ord_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LINK_W-1:0] i_q, i_d, j_q, j_d, b_q, b_d, pr_q, pr_d, nx_q, nx_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [PAGE_W-1:0] p_q, p_d, h_page_q, h_page_d, blk_q, blk_d;
  stat_e             status_q, status_d;

  meta_req_t meta_req;
  meta_t     meta_rd;
  link_req_t link_req;
  link_t     link_rd;

  bpa_meta_mem u_meta (.clk_i(clk_i), .req_i(meta_req), .rdata_o(meta_rd));
  bpa_link_mem u_link (.clk_i(clk_i), .req_i(link_req), .rdata_o(link_rd));

  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign cfg_ready_o = 1'b1;
  assign rsp_o.status      = status_q;
  assign rsp_o.block_index = IDX_W'(blk_q);
  assign rsp_o.free_total  = FREE_W'(free_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_count_q <= LINK_W'(4096);
      cfg_res_q   <= LINK_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:  cfg_base_q  <= cfg_data_i;
        CFG_COUNT: cfg_count_q <= cfg_data_i[LINK_W-1:0];
        CFG_RSVD:  cfg_res_q   <= cfg_data_i[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LINK_W-1:0] n_v, r_v, step, bcand, size_v, p_ext;
    logic [BASE_W-1:0] bsum;
    logic [ORD_W-1:0]  mo_v;
    logic              run, cond, up;

    state_d = state_q;  ret_d = ret_q;
    held_base_d = held_base_q;  held_n_d = held_n_q;  held_r_d = held_r_q;
    largest_d = largest_q;  free_d = free_q;
    cnt_d = cnt_q;  head_d = head_q;  tail_d = tail_q;
    ord_d = ord_q;  mo_d = mo_q;  o_d = o_q;  lim_d = lim_q;  h_ord_d = h_ord_q;
    idx_d = idx_q;  i_d = i_q;  j_d = j_q;  b_d = b_q;  pr_d = pr_q;  nx_d = nx_q;
    k_d = k_q;  p_d = p_q;  h_page_d = h_page_q;  blk_d = blk_q;  status_d = status_q;
    meta_req = '0;
    link_req = '0;

    n_v    = (cfg_count_q > LINK_W'(NUM_PAGES)) ? LINK_W'(NUM_PAGES) : cfg_count_q;
    r_v    = (cfg_res_q > n_v) ? n_v : cfg_res_q;
    size_v = LINK_W'(1) << mo_q;
    p_ext  = {1'b0, p_q};
    step   = LINK_W'(1) << o_q;
    bsum   = held_base_q + BASE_W'(p_q);
    up     = bsum[o_q];
    bcand  = '0;
    cond   = 1'b0;

    // largest aligned block whose end lies strictly before the region end
    mo_v = '0;
    run  = 1'b1;
    for (int m = 0; m < NUM_ORDERS - 1; m++) begin
      run = run && ((BASE_W'(i_q) + (BASE_W'(2) << m)) < BASE_W'(held_n_q)) &&
            (((held_base_q + BASE_W'(i_q)) & ((BASE_W'(2) << m) - BASE_W'(1))) == '0);
      if (run) mo_v = ORD_W'(m + 1);
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          ord_d    = req_i.request_order;
          idx_d    = req_i.page_index;
          status_d = ST_OK;
          blk_d    = '0;
          case (op_e'(req_i.operation))
            OP_INIT:  state_d = S_INIT;
            OP_ALLOC: state_d = S_A_CHK;
            OP_FREE:  state_d = S_F_CHK;
            default: begin
              status_d = ST_BAD;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      // init: latch region, clear lists, mark reserved pages, carve blocks
      S_INIT: begin
        held_base_d = cfg_base_q;
        held_n_d    = n_v;
        held_r_d    = r_v;
        largest_d   = '0;
        free_d      = n_v - r_v;
        for (int l = 0; l < NUM_LISTS; l++) cnt_d[l] = '0;
        i_d     = '0;
        state_d = S_I_RES;
      end
      S_I_RES: begin
        if (i_q < held_r_q) begin
          meta_req.wr_alloc = 1'b1;
          meta_req.wr_order = 1'b1;
          meta_req.wr_limit = 1'b1;
          meta_req.addr     = i_q[PAGE_W-1:0];
          meta_req.wdata    = '{alloc: 1'b1, order: '0, limit: '0};
          i_d = i_q + LINK_W'(1);
        end else begin
          state_d = S_I_CARVE;
        end
      end
      S_I_CARVE: begin
        if (i_q >= held_n_q) begin
          state_d = S_DONE;
        end else begin
          mo_d = mo_v;
          if (mo_v > largest_q) largest_d = mo_v;
          j_d     = i_q;
          state_d = S_I_FILL;
        end
      end
      S_I_FILL: begin
        meta_req.wr_alloc = 1'b1;
        meta_req.wr_order = 1'b1;
        meta_req.wr_limit = 1'b1;
        meta_req.addr     = j_q[PAGE_W-1:0];
        meta_req.wdata    = '{alloc: 1'b0, order: mo_q, limit: mo_q};
        if (j_q == i_q + size_v - LINK_W'(1)) begin
          h_ord_d  = mo_q;
          h_page_d = i_q[PAGE_W-1:0];
          ret_d    = S_I_NEXT;
          state_d  = S_PT1;
        end else begin
          j_d = j_q + LINK_W'(1);
        end
      end
      S_I_NEXT: begin
        i_d     = i_q + size_v;
        state_d = S_I_CARVE;
      end

      // alloc: search upward, unlink, split down
      S_A_CHK: begin
        if ({1'b0, ord_q} >= K_W'(NUM_ORDERS)) begin
          status_d = ST_BAD;
          state_d  = S_DONE;
        end else if (ord_q > largest_q) begin
          status_d = ST_NOFREE;
          state_d  = S_DONE;
        end else begin
          k_d     = {1'b0, ord_q};
          state_d = S_A_SRCH;
        end
      end
      S_A_SRCH: begin
        if (k_q >= K_W'(NUM_ORDERS)) begin
          status_d = ST_NOFREE;
          state_d  = S_DONE;
        end else if (cnt_q[k_q[ORD_W-1:0]] == '0) begin
          k_d = k_q + K_W'(1);
        end else if (head_q[k_q[ORD_W-1:0]] >= NO_LINK) begin
          status_d = ST_NOFREE;
          state_d  = S_DONE;
        end else begin
          p_d      = head_q[k_q[ORD_W-1:0]][PAGE_W-1:0];
          h_ord_d  = k_q[ORD_W-1:0];
          h_page_d = head_q[k_q[ORD_W-1:0]][PAGE_W-1:0];
          ret_d    = S_A_SPLIT;
          state_d  = S_U1;
        end
      end
      S_A_SPLIT: begin
        if (k_q > {1'b0, ord_q}) begin
          k_d   = k_q - K_W'(1);
          bcand = p_ext + (LINK_W'(1) << (k_q[ORD_W-1:0] - ORD_W'(1)));
          if (bcand < NO_LINK) begin
            meta_req.wr_order    = 1'b1;
            meta_req.addr        = bcand[PAGE_W-1:0];
            meta_req.wdata.order = k_q[ORD_W-1:0] - ORD_W'(1);
            h_ord_d  = k_q[ORD_W-1:0] - ORD_W'(1);
            h_page_d = bcand[PAGE_W-1:0];
            ret_d    = S_A_SPLIT;
            state_d  = S_PT1;
          end
        end else begin
          meta_req.wr_alloc = 1'b1;
          meta_req.wr_order = 1'b1;
          meta_req.addr     = p_q;
          meta_req.wdata    = '{alloc: 1'b1, order: ord_q, limit: '0};
          free_d  = free_q - (LINK_W'(1) << ord_q);
          blk_d   = p_q;
          state_d = S_DONE;
        end
      end

      // free: check, clear mark, merge with free buddies, push at head
      S_F_CHK: begin
        if ({1'b0, ord_q} >= K_W'(NUM_ORDERS) || LINK_W'(idx_q) >= held_n_q ||
            LINK_W'(idx_q) < held_r_q) begin
          status_d = ST_BAD;
          state_d  = S_DONE;
        end else begin
          meta_req.rd   = 1'b1;
          meta_req.addr = PAGE_W'(idx_q);
          state_d = S_F_META;
        end
      end
      S_F_META: begin
        if (!meta_rd.alloc) begin
          status_d = ST_DOUBLE;
          state_d  = S_DONE;
        end else if (meta_rd.order != ord_q) begin
          status_d = ST_BAD;
          state_d  = S_DONE;
        end else begin
          meta_req.wr_alloc    = 1'b1;
          meta_req.addr        = PAGE_W'(idx_q);
          meta_req.wdata.alloc = 1'b0;
          lim_d   = meta_rd.limit;
          o_d     = ord_q;
          p_d     = PAGE_W'(idx_q);
          state_d = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (o_q < lim_q) begin
          if (up && p_ext < step) begin
            state_d = S_F_FIN;
          end else begin
            bcand = up ? (p_ext - step) : (p_ext + step);
            if (bcand >= held_n_q) begin
              state_d = S_F_FIN;
            end else begin
              meta_req.rd   = 1'b1;
              meta_req.addr = bcand[PAGE_W-1:0];
              b_d     = bcand;
              state_d = S_F_BUD;
            end
          end
        end else begin
          state_d = S_F_FIN;
        end
      end
      S_F_BUD: begin
        if (meta_rd.alloc || meta_rd.order != o_q || meta_rd.limit != lim_q) begin
          state_d = S_F_FIN;
        end else begin
          h_ord_d  = o_q;
          h_page_d = b_q[PAGE_W-1:0];
          ret_d    = S_F_MERGE;
          state_d  = S_U1;
        end
      end
      S_F_MERGE: begin
        meta_req.wr_order    = 1'b1;
        meta_req.addr        = b_q[PAGE_W-1:0];
        meta_req.wdata.order = o_q + ORD_W'(1);
        if (b_q < p_ext) p_d = b_q[PAGE_W-1:0];
        o_d     = o_q + ORD_W'(1);
        state_d = S_F_ORD;
      end
      S_F_ORD: begin
        meta_req.wr_order    = 1'b1;
        meta_req.addr        = p_q;
        meta_req.wdata.order = o_q;
        state_d = S_F_LOOP;
      end
      S_F_FIN: begin
        meta_req.wr_order    = 1'b1;
        meta_req.addr        = p_q;
        meta_req.wdata.order = o_q;
        h_ord_d  = o_q;
        h_page_d = p_q;
        ret_d    = S_F_DONE;
        state_d  = S_PH1;
      end
      S_F_DONE: begin
        free_d  = free_q + (LINK_W'(1) << ord_q);
        state_d = S_DONE;
      end

      // push at tail: link old tail forward, then write the new entry
      S_PT1: begin
        cond = (cnt_q[h_ord_q] != '0) && (tail_q[h_ord_q] < NO_LINK);
        if (cond) begin
          link_req.wr_next    = 1'b1;
          link_req.addr       = tail_q[h_ord_q][PAGE_W-1:0];
          link_req.wdata.next = {1'b0, h_page_q};
        end
        state_d = S_PT2;
      end
      S_PT2: begin
        cond = (cnt_q[h_ord_q] != '0) && (tail_q[h_ord_q] < NO_LINK);
        link_req.wr_next = 1'b1;
        link_req.wr_prev = 1'b1;
        link_req.addr    = h_page_q;
        link_req.wdata   = '{next: NO_LINK, prev: cond ? tail_q[h_ord_q] : NO_LINK};
        if (!cond) head_d[h_ord_q] = {1'b0, h_page_q};
        tail_d[h_ord_q] = {1'b0, h_page_q};
        cnt_d[h_ord_q]  = cnt_q[h_ord_q] + LINK_W'(1);
        state_d = ret_q;
      end

      // push at head: link old head back, then write the new entry
      S_PH1: begin
        cond = (cnt_q[h_ord_q] != '0) && (head_q[h_ord_q] < NO_LINK);
        if (cond) begin
          link_req.wr_prev    = 1'b1;
          link_req.addr       = head_q[h_ord_q][PAGE_W-1:0];
          link_req.wdata.prev = {1'b0, h_page_q};
        end
        state_d = S_PH2;
      end
      S_PH2: begin
        cond = (cnt_q[h_ord_q] != '0) && (head_q[h_ord_q] < NO_LINK);
        link_req.wr_next = 1'b1;
        link_req.wr_prev = 1'b1;
        link_req.addr    = h_page_q;
        link_req.wdata   = '{next: cond ? head_q[h_ord_q] : NO_LINK, prev: NO_LINK};
        if (!cond) tail_d[h_ord_q] = {1'b0, h_page_q};
        head_d[h_ord_q] = {1'b0, h_page_q};
        cnt_d[h_ord_q]  = cnt_q[h_ord_q] + LINK_W'(1);
        state_d = ret_q;
      end

      // unlink: read links, patch the neighbor on each side
      S_U1: begin
        if (cnt_q[h_ord_q] == '0) begin
          state_d = ret_q;
        end else begin
          link_req.rd   = 1'b1;
          link_req.addr = h_page_q;
          state_d = S_U2;
        end
      end
      S_U2: begin
        pr_d = link_rd.prev;
        nx_d = link_rd.next;
        if (link_rd.prev < NO_LINK) begin
          link_req.wr_next    = 1'b1;
          link_req.addr       = link_rd.prev[PAGE_W-1:0];
          link_req.wdata.next = link_rd.next;
        end else begin
          head_d[h_ord_q] = link_rd.next;
        end
        state_d = S_U3;
      end
      S_U3: begin
        if (nx_q < NO_LINK) begin
          link_req.wr_prev    = 1'b1;
          link_req.addr       = nx_q[PAGE_W-1:0];
          link_req.wdata.prev = pr_q;
        end else begin
          tail_d[h_ord_q] = pr_q;
        end
        cnt_d[h_ord_q] = cnt_q[h_ord_q] - LINK_W'(1);
        state_d = ret_q;
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      held_base_q <= '0;
      held_n_q    <= '0;
      held_r_q    <= '0;
      largest_q   <= '0;
      free_q      <= '0;
      for (int l = 0; l < NUM_LISTS; l++) cnt_q[l] <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      held_base_q <= held_base_d;
      held_n_q    <= held_n_d;
      held_r_q    <= held_r_d;
      largest_q   <= largest_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    tail_q   <= tail_d;
    ord_q    <= ord_d;
    mo_q     <= mo_d;
    o_q      <= o_d;
    lim_q    <= lim_d;
    h_ord_q  <= h_ord_d;
    idx_q    <= idx_d;
    i_q      <= i_d;
    j_q      <= j_d;
    b_q      <= b_d;
    pr_q     <= pr_d;
    nx_q     <= nx_d;
    k_q      <= k_d;
    p_q      <= p_d;
    h_page_q <= h_page_d;
    blk_q    <= blk_d;
    status_q <= status_d;
  end

  // busy rises once a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // release busy right after the done strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy held after result");

  // drop the block head on every failed request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && rsp_o.status != ST_OK) |-> (rsp_o.block_index == '0))
    else $error("block head reported on failure");

  // free count reported with each result never exceeds NUM_PAGES
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> (rsp_o.free_total <= FREE_W'(NUM_PAGES)))
    else $error("free page count out of range");

endmodule
